// ===== src/ntc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the ln(1+f) table for the NTC temperature converter.
// No dependencies.
package ntc_pkg;

   localparam int ADC_BITS_DEF = 10;
   localparam int OHMS_W       = 22;
   localparam int BETA_W       = 14;
   localparam int T0_W         = 16;
   localparam int TEMP_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int FRAC_W       = 20;
   localparam int TAB_W        = 16;
   localparam int QUO_W        = 16;

   localparam logic [16:0] LN2_Q16       = 17'd45426;
   localparam logic [22:0] BETA_SCALE    = 23'd6553600;   // 100 * 2^16
   localparam int          BETA_TERM_W   = BETA_W + 23;
   localparam int          NUM_W         = T0_W + BETA_W + 23;
   localparam logic [15:0] ZERO_C_CENTIK = 16'd27315;
   localparam logic [15:0] OUT_MAX       = 16'd32767;

   localparam logic [OHMS_W-1:0] SERIES_RST  = 22'd90600;
   localparam logic [OHMS_W-1:0] NOMINAL_RST = 22'd100000;
   localparam logic [BETA_W-1:0] BETA_RST    = 14'd4014;
   localparam logic [T0_W-1:0]   T0_RST      = 16'd29815;

   localparam logic [CSR_IDX_W-1:0] CSR_SERIES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_T0      = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RAIL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

   typedef enum logic [1:0] {
      PRE_OK   = 2'd0,
      PRE_RAIL = 2'd1,
      PRE_HOT  = 2'd2,
      PRE_COLD = 2'd3
   } pre_type;

   function automatic logic [TAB_W-1:0] ln1p(input logic [4:0] i);
      logic [TAB_W-1:0] v;
      case (i)
         5'd0:    v = 16'd0;
         5'd1:    v = 16'd3973;
         5'd2:    v = 16'd7719;
         5'd3:    v = 16'd11262;
         5'd4:    v = 16'd14624;
         5'd5:    v = 16'd17821;
         5'd6:    v = 16'd20870;
         5'd7:    v = 16'd23783;
         5'd8:    v = 16'd26573;
         5'd9:    v = 16'd29248;
         5'd10:   v = 16'd31818;
         5'd11:   v = 16'd34292;
         5'd12:   v = 16'd36675;
         5'd13:   v = 16'd38975;
         5'd14:   v = 16'd41196;
         5'd15:   v = 16'd43345;
         5'd16:   v = 16'd45426;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/ntc_ln.sv =====
`timescale 1ns / 1ps
// Three-stage natural log in Q16: leading-one search, table lookup with
// interpolation product, final sum. Uses ntc_pkg.
module ntc_ln #(
   parameter int XW = 32
) (
   input  logic                                         clock,
   input  logic                                         en,
   input  logic [XW-1:0]                                x,
   output logic [$clog2((XW+1)*ntc_pkg::LN2_Q16)-1:0]   y
);
   localparam int YW = $clog2((XW+1)*ntc_pkg::LN2_Q16);
   localparam int PW = $clog2(XW);

   logic [XW-1:0]               x1_ff;
   logic [PW-1:0]               p1_ff, p_in;
   logic [YW-1:0]               base2_ff, base2_in;
   logic [28:0]                 prod2_ff, prod2_in;
   logic [YW-1:0]               y3_ff;
   logic [XW-1:0]               shifted;
   logic [ntc_pkg::FRAC_W-1:0]  frac;
   logic [4:0]                  idx;
   logic [ntc_pkg::TAB_W-1:0]   t_lo, t_hi;
   logic [12:0]                 d;

   always_comb begin
      p_in = '0;
      for (int k = 0; k < XW; k++) begin
         if (x[k]) p_in = PW'(k);
      end
   end

   always_comb begin
      shifted  = x1_ff << (PW'(XW-1) - p1_ff);
      frac     = shifted[XW-2 -: ntc_pkg::FRAC_W];
      idx      = {1'b0, frac[19:16]};
      t_lo     = ntc_pkg::ln1p(idx);
      t_hi     = ntc_pkg::ln1p(idx + 5'd1);
      d        = 13'(t_hi - t_lo);
      prod2_in = 29'(d * frac[15:0]);
      base2_in = YW'(p1_ff * ntc_pkg::LN2_Q16) + YW'(t_lo);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x;
         p1_ff    <= p_in;
         base2_ff <= base2_in;
         prod2_ff <= prod2_in;
         y3_ff    <= base2_ff + YW'((prod2_ff + 29'd32768) >> 16);
      end
   end

   assign y = y3_ff;

endmodule

// ===== src/ntc_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one overflow stage, then one quotient bit per
// stage. Carries a valid bit and a tag. Uses ntc_pkg.
module ntc_div #(
   parameter int RW = 56,
   parameter int DU = 38
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [RW-1:0]                 in_num,
   input  logic [DU-1:0]                 in_den,
   input  ntc_pkg::pre_type              in_tag,
   output logic                          out_valid,
   output logic [ntc_pkg::QUO_W-1:0]     out_quo,
   output logic                          out_ovf,
   output ntc_pkg::pre_type              out_tag
);
   localparam int QW = ntc_pkg::QUO_W;
   localparam int NS = QW + 1;

   logic [RW-1:0]    rem_ff [0:NS];
   logic [DU-1:0]    den_ff [0:NS];
   logic [QW-1:0]    quo_ff [0:NS];
   logic             ovf_ff [0:NS];
   ntc_pkg::pre_type tag_ff [0:NS];
   logic             vld_ff [0:NS];

   logic [RW-1:0]    rem_in [1:NS];
   logic [QW-1:0]    quo_in [1:NS];
   logic             ovf_in [1:NS];

   always_comb begin
      logic [RW-1:0] dsh;
      dsh = '0;
      for (int j = 1; j <= NS; j++) begin
         dsh = {{(RW-DU){1'b0}}, den_ff[j-1]} << (NS - j);
         rem_in[j] = rem_ff[j-1];
         quo_in[j] = quo_ff[j-1];
         ovf_in[j] = ovf_ff[j-1];
         if (j == 1) begin
            ovf_in[j] = (rem_ff[j-1] >= dsh);
         end else if (rem_ff[j-1] >= dsh) begin
            rem_in[j] = rem_ff[j-1] - dsh;
            quo_in[j] = {quo_ff[j-1][QW-2:0], 1'b1};
         end else begin
            quo_in[j] = {quo_ff[j-1][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NS; j++) vld_ff[j] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int j = 1; j <= NS; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= in_num;
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= 1'b0;
         tag_ff[0] <= in_tag;
         for (int j = 1; j <= NS; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= quo_in[j];
            ovf_ff[j] <= ovf_in[j];
            tag_ff[j] <= tag_ff[j-1];
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_quo   = quo_ff[NS];
   assign out_ovf   = ovf_ff[NS];
   assign out_tag   = tag_ff[NS];

endmodule

// ===== src/ntc_adc_to_temperature.sv =====
`timescale 1ns / 1ps
// Top level of the NTC thermistor converter (beta equation, Celsius output).
// Uses ntc_pkg, ntc_ln and ntc_div.

// Converts one divider sample per clock into hundredths of a degree Celsius.
// Throughput is one item per cycle while the result is not stalled; the path from acceptance
// to the result register is the input multiply, 3-stage log unit, 4 arithmetic stages, and an
// 18-stage divider: input register, overflow check and the 16 quotient bits.
// The whole pipeline advances together and holds while the result is stalled.
// status: 0 valid, 1 code at top rail (temperature 0), 2 saturated.
// Write the configuration registers only while no item is in flight.
module ntc_adc_to_temperature #(
   parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ADC_BITS-1:0]               req_adc_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ntc_pkg::TEMP_W-1:0] rsp_temp_centi_c,
   output logic [ntc_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              csr_we,
   input  logic [ntc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ntc_pkg::OHMS_W-1:0]        csr_wdata
);
   localparam int XW  = ntc_pkg::OHMS_W + ADC_BITS;
   localparam int YW  = $clog2((XW+1)*ntc_pkg::LN2_Q16);
   localparam int LQW = YW + 1;
   localparam int MW  = LQW + ntc_pkg::T0_W + 1;
   localparam int DW  = ((MW > ntc_pkg::BETA_TERM_W) ? MW : ntc_pkg::BETA_TERM_W) + 2;
   localparam int DU  = DW - 1;
   localparam int RW  = ((ntc_pkg::NUM_W > DU + 16) ? ntc_pkg::NUM_W : DU + 16) + 2;
   localparam int LNL = 3;

   logic [ntc_pkg::OHMS_W-1:0] series_ff, nominal_ff;
   logic [ntc_pkg::BETA_W-1:0] beta_ff;
   logic [ntc_pkg::T0_W-1:0]   t0_ff;

   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= ntc_pkg::SERIES_RST;
         nominal_ff <= ntc_pkg::NOMINAL_RST;
         beta_ff    <= ntc_pkg::BETA_RST;
         t0_ff      <= ntc_pkg::T0_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ntc_pkg::CSR_SERIES:  series_ff  <= csr_wdata;
            ntc_pkg::CSR_NOMINAL: nominal_ff <= csr_wdata;
            ntc_pkg::CSR_BETA:    beta_ff    <= csr_wdata[ntc_pkg::BETA_W-1:0];
            ntc_pkg::CSR_T0:      t0_ff      <= csr_wdata[ntc_pkg::T0_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: divider products and early special cases
   logic [ADC_BITS:0]  code_p1, low_side;
   ntc_pkg::pre_type   pre1_in;
   logic [XW-1:0]      xhi1_ff, xlo1_ff;

   always_comb begin
      code_p1  = {1'b0, req_adc_code} + 1'b1;
      low_side = {1'b1, {ADC_BITS{1'b0}}} - code_p1;
      if (&req_adc_code)              pre1_in = ntc_pkg::PRE_RAIL;
      else if (series_ff == '0)       pre1_in = ntc_pkg::PRE_HOT;
      else if (nominal_ff == '0)      pre1_in = ntc_pkg::PRE_COLD;
      else                            pre1_in = ntc_pkg::PRE_OK;
   end

   logic             vld_ff [1:LNL+1];
   ntc_pkg::pre_type pre_ff [1:LNL+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= LNL+1; j++) vld_ff[j] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int j = 2; j <= LNL+1; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff[1] <= pre1_in;
         for (int j = 2; j <= LNL+1; j++) pre_ff[j] <= pre_ff[j-1];
         xhi1_ff <= XW'(series_ff * code_p1);
         xlo1_ff <= XW'(nominal_ff * low_side);
      end
   end

   logic [YW-1:0] yhi, ylo;

   ntc_ln #(.XW(XW)) u_ln_hi (.clock(clock), .en(adv), .x(xhi1_ff), .y(yhi));
   ntc_ln #(.XW(XW)) u_ln_lo (.clock(clock), .en(adv), .x(xlo1_ff), .y(ylo));

   // stages 5 to 8: log ratio, denominator, rounded numerator
   logic                                 v5_ff, v6_ff, v7_ff, v8_ff;
   ntc_pkg::pre_type                     pre5_ff, pre6_ff, pre7_ff, pre8_ff;
   logic signed [LQW-1:0]                lq5_ff;
   logic signed [MW-1:0]                 m6_ff;
   logic [ntc_pkg::BETA_TERM_W-1:0]      bt6_ff;
   logic [ntc_pkg::T0_W+ntc_pkg::BETA_W-1:0] tb6_ff;
   logic signed [DW-1:0]                 den7_ff;
   logic [ntc_pkg::NUM_W-1:0]            num7_ff;
   logic [RW-1:0]                        n8_ff;
   logic [DU-1:0]                        d8_ff;
   logic                                 den_pos;

   assign den_pos = !den7_ff[DW-1] && (den7_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= vld_ff[LNL+1];
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre5_ff <= pre_ff[LNL+1];
         lq5_ff  <= $signed({1'b0, yhi}) - $signed({1'b0, ylo});
         pre6_ff <= pre5_ff;
         m6_ff   <= MW'(lq5_ff * $signed({1'b0, t0_ff}));
         bt6_ff  <= ntc_pkg::BETA_TERM_W'(beta_ff * ntc_pkg::BETA_SCALE);
         tb6_ff  <= t0_ff * beta_ff;
         pre7_ff <= pre6_ff;
         den7_ff <= DW'(m6_ff) + $signed(DW'(bt6_ff));
         num7_ff <= ntc_pkg::NUM_W'(tb6_ff * ntc_pkg::BETA_SCALE);
         pre8_ff <= (pre7_ff == ntc_pkg::PRE_OK && !den_pos) ? ntc_pkg::PRE_HOT : pre7_ff;
         n8_ff   <= RW'(num7_ff) + RW'(den7_ff[DU-1:1]);
         d8_ff   <= den7_ff[DU-1:0];
      end
   end

   logic                        dv;
   logic [ntc_pkg::QUO_W-1:0]   dq;
   logic                        dovf;
   ntc_pkg::pre_type            dtag;

   ntc_div #(.RW(RW), .DU(DU)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v8_ff),
      .in_num   (n8_ff),
      .in_den   (d8_ff),
      .in_tag   (pre8_ff),
      .out_valid(dv),
      .out_quo  (dq),
      .out_ovf  (dovf),
      .out_tag  (dtag)
   );

   // result register
   logic [ntc_pkg::TEMP_W-1:0]        temp_ff, temp_in;
   logic [ntc_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic signed [ntc_pkg::QUO_W:0]    tc;

   always_comb begin
      tc = $signed({1'b0, dq}) - $signed({1'b0, ntc_pkg::ZERO_C_CENTIK});
      case (dtag)
         ntc_pkg::PRE_RAIL: begin
            temp_in   = '0;
            status_in = ntc_pkg::ST_RAIL;
         end
         ntc_pkg::PRE_HOT: begin
            temp_in   = ntc_pkg::OUT_MAX;
            status_in = ntc_pkg::ST_SAT;
         end
         ntc_pkg::PRE_COLD: begin
            temp_in   = -ntc_pkg::ZERO_C_CENTIK;
            status_in = ntc_pkg::ST_SAT;
         end
         default: begin
            if (dovf || tc > $signed({1'b0, ntc_pkg::OUT_MAX})) begin
               temp_in   = ntc_pkg::OUT_MAX;
               status_in = ntc_pkg::ST_SAT;
            end else begin
               temp_in   = tc[ntc_pkg::TEMP_W-1:0];
               status_in = ntc_pkg::ST_OK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         temp_ff   <= temp_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_centi_c = $signed(temp_ff);
   assign rsp_status       = status_ff;

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall not tied to a held result");

   a_rail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ntc_pkg::ST_RAIL |-> rsp_temp_centi_c == '0)
      else $error("top rail result carries a temperature");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ntc_pkg::ST_OK |->
         rsp_temp_centi_c >= -$signed({1'b0, ntc_pkg::ZERO_C_CENTIK}))
      else $error("valid result below absolute zero");

endmodule
